// ----- hdl/file_transfer_packet_parser_macros.svh -----
// Assertion macros used by the packet parser module
`ifndef FILE_TRANSFER_PACKET_PARSER_MACROS_SVH
`define FILE_TRANSFER_PACKET_PARSER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define FTPP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define FTPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ftpp_pkg.sv -----
// Types and constants of the file transfer packet parser
package ftpp_pkg;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [2:0] REG_DATA_TYPE  = 3'd0;
  localparam logic [2:0] REG_START_TYPE = 3'd1;
  localparam logic [2:0] REG_END_TYPE   = 3'd2;
  localparam logic [2:0] REG_SIZE_TAG   = 3'd3;
  localparam logic [2:0] REG_NAME_TAG   = 3'd4;

  localparam logic [7:0] RST_DATA_TYPE  = 8'd1;
  localparam logic [7:0] RST_START_TYPE = 8'd2;
  localparam logic [7:0] RST_END_TYPE   = 8'd3;
  localparam logic [7:0] RST_SIZE_TAG   = 8'd0;
  localparam logic [7:0] RST_NAME_TAG   = 8'd1;

  localparam logic [7:0] SEQ_WRAP = 8'd254;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_DSEQ  = 4'd1,
    PH_DLENH = 4'd2,
    PH_DLENL = 4'd3,
    PH_DPAY  = 4'd4,
    PH_CTAG  = 4'd5,
    PH_CSLEN = 4'd6,
    PH_CSIZE = 4'd7,
    PH_CNTAG = 4'd8,
    PH_CNLEN = 4'd9,
    PH_CNAME = 4'd10
  } phase_e;

  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_NAME    = 3'd1,
    KIND_SIZE    = 3'd2,
    KIND_FORMAT  = 3'd3,
    KIND_SEQ     = 3'd4
  } kind_e;

  typedef struct packed {
    logic [7:0] data_type;
    logic [7:0] start_type;
    logic [7:0] end_type;
    logic [7:0] size_tag;
    logic [7:0] name_tag;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic        last;
    logic        is_end;
  } result_t;

endpackage

// ----- hdl/ftpp_cfg_regs.sv -----
// APB configuration registers of the packet parser
module ftpp_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ftpp_pkg::PADDR_W-1:0] paddr,
  input  logic [ftpp_pkg::PDATA_W-1:0] pwdata,
  output logic [ftpp_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output ftpp_pkg::cfg_t               cfg_o
);

  ftpp_pkg::cfg_t cfg_q;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[ftpp_pkg::PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.data_type  <= ftpp_pkg::RST_DATA_TYPE;
      cfg_q.start_type <= ftpp_pkg::RST_START_TYPE;
      cfg_q.end_type   <= ftpp_pkg::RST_END_TYPE;
      cfg_q.size_tag   <= ftpp_pkg::RST_SIZE_TAG;
      cfg_q.name_tag   <= ftpp_pkg::RST_NAME_TAG;
    end else if (wr_en) begin
      unique case (reg_idx)
        ftpp_pkg::REG_DATA_TYPE:  cfg_q.data_type  <= pwdata[7:0];
        ftpp_pkg::REG_START_TYPE: cfg_q.start_type <= pwdata[7:0];
        ftpp_pkg::REG_END_TYPE:   cfg_q.end_type   <= pwdata[7:0];
        ftpp_pkg::REG_SIZE_TAG:   cfg_q.size_tag   <= pwdata[7:0];
        ftpp_pkg::REG_NAME_TAG:   cfg_q.name_tag   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      ftpp_pkg::REG_DATA_TYPE:  prdata[7:0] = cfg_q.data_type;
      ftpp_pkg::REG_START_TYPE: prdata[7:0] = cfg_q.start_type;
      ftpp_pkg::REG_END_TYPE:   prdata[7:0] = cfg_q.end_type;
      ftpp_pkg::REG_SIZE_TAG:   prdata[7:0] = cfg_q.size_tag;
      ftpp_pkg::REG_NAME_TAG:   prdata[7:0] = cfg_q.name_tag;
      default:                  prdata = '0;
    endcase
  end

endmodule

// ----- hdl/ftpp_in_reg.sv -----
// Input register stage holding one received word
module ftpp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_i,
  input  logic       first_i,
  input  logic       adv_i,
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       first_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       first_q;

  assign in_ready_o = !valid_q || adv_i;
  assign valid_o    = valid_q;
  assign byte_o     = byte_q;
  assign first_o    = first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q  <= byte_i;
      first_q <= first_i;
    end
  end

endmodule

// ----- hdl/ftpp_parser.sv -----
// Packet parser state machine: one word in, zero or one result out
`include "file_transfer_packet_parser_macros.svh"

module ftpp_parser #(
  parameter int SIZE_BYTES_KEPT = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ftpp_pkg::cfg_t    cfg_i,
  input  logic              adv_i,
  input  logic [7:0]        byte_i,
  input  logic              first_i,
  output logic              res_valid_o,
  output ftpp_pkg::result_t res_o
);

  localparam int KEPT = (SIZE_BYTES_KEPT < 4) ? SIZE_BYTES_KEPT : 4;

  ftpp_pkg::phase_e phase_q, phase_d;
  logic [7:0]       seq_q, seq_d;
  logic [15:0]      rem_q, rem_d;
  logic [31:0]      acc_q, acc_d;
  logic [7:0]       idx_q, idx_d;
  logic             ctl_end_q, ctl_end_d;
  logic [15:0]      dlen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ftpp_pkg::PH_IDLE;
      seq_q     <= '0;
      rem_q     <= '0;
      acc_q     <= '0;
      idx_q     <= '0;
      ctl_end_q <= 1'b0;
    end else if (adv_i) begin
      phase_q   <= phase_d;
      seq_q     <= seq_d;
      rem_q     <= rem_d;
      acc_q     <= acc_d;
      idx_q     <= idx_d;
      ctl_end_q <= ctl_end_d;
    end
  end

  assign dlen = {rem_q[15:8], byte_i};

  always_comb begin
    phase_d     = phase_q;
    seq_d       = seq_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    idx_d       = idx_q;
    ctl_end_d   = ctl_end_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: ftpp_pkg::KIND_PAYLOAD, value: 32'd0, last: 1'b0, is_end: 1'b0};

    if (first_i) begin
      if (byte_i == cfg_i.data_type) begin
        phase_d = ftpp_pkg::PH_DSEQ;
      end else if (byte_i == cfg_i.start_type || byte_i == cfg_i.end_type) begin
        ctl_end_d = (byte_i != cfg_i.start_type);
        phase_d   = ftpp_pkg::PH_CTAG;
      end else begin
        phase_d     = ftpp_pkg::PH_IDLE;
        res_valid_o = 1'b1;
        res_o.kind  = ftpp_pkg::KIND_FORMAT;
      end
    end else begin
      unique case (phase_q)
        ftpp_pkg::PH_DSEQ: begin
          if (byte_i != seq_q) begin
            phase_d     = ftpp_pkg::PH_IDLE;
            res_valid_o = 1'b1;
            res_o.kind  = ftpp_pkg::KIND_SEQ;
          end else begin
            seq_d   = (seq_q == ftpp_pkg::SEQ_WRAP) ? 8'd0 : seq_q + 8'd1;
            phase_d = ftpp_pkg::PH_DLENH;
          end
        end
        ftpp_pkg::PH_DLENH: begin
          rem_d   = {byte_i, 8'h00};
          phase_d = ftpp_pkg::PH_DLENL;
        end
        ftpp_pkg::PH_DLENL: begin
          rem_d   = dlen;
          phase_d = (dlen == 16'd0) ? ftpp_pkg::PH_IDLE : ftpp_pkg::PH_DPAY;
        end
        ftpp_pkg::PH_DPAY: begin
          rem_d       = rem_q - 16'd1;
          res_valid_o = 1'b1;
          res_o.kind  = ftpp_pkg::KIND_PAYLOAD;
          res_o.value = {24'd0, byte_i};
          res_o.last  = (rem_q == 16'd1);
          if (rem_q == 16'd1) begin
            phase_d = ftpp_pkg::PH_IDLE;
          end
        end
        ftpp_pkg::PH_CTAG: begin
          if (byte_i != cfg_i.size_tag) begin
            phase_d     = ftpp_pkg::PH_IDLE;
            res_valid_o = 1'b1;
            res_o.kind  = ftpp_pkg::KIND_FORMAT;
          end else begin
            phase_d = ftpp_pkg::PH_CSLEN;
          end
        end
        ftpp_pkg::PH_CSLEN: begin
          acc_d = '0;
          idx_d = '0;
          rem_d = {8'd0, byte_i};
          if (byte_i == 8'd0) begin
            phase_d      = ftpp_pkg::PH_CNTAG;
            res_valid_o  = 1'b1;
            res_o.kind   = ftpp_pkg::KIND_SIZE;
            res_o.is_end = ctl_end_q;
          end else begin
            phase_d = ftpp_pkg::PH_CSIZE;
          end
        end
        ftpp_pkg::PH_CSIZE: begin
          if (idx_q < 8'(KEPT)) begin
            acc_d = acc_q | ({24'd0, byte_i} << {idx_q[1:0], 3'b000});
          end
          idx_d = idx_q + 8'd1;
          rem_d = rem_q - 16'd1;
          if (rem_q == 16'd1) begin
            phase_d      = ftpp_pkg::PH_CNTAG;
            res_valid_o  = 1'b1;
            res_o.kind   = ftpp_pkg::KIND_SIZE;
            res_o.value  = acc_d;
            res_o.is_end = ctl_end_q;
          end
        end
        ftpp_pkg::PH_CNTAG: begin
          if (byte_i != cfg_i.name_tag) begin
            phase_d     = ftpp_pkg::PH_IDLE;
            res_valid_o = 1'b1;
            res_o.kind  = ftpp_pkg::KIND_FORMAT;
          end else begin
            phase_d = ftpp_pkg::PH_CNLEN;
          end
        end
        ftpp_pkg::PH_CNLEN: begin
          rem_d   = {8'd0, byte_i};
          phase_d = (byte_i == 8'd0) ? ftpp_pkg::PH_IDLE : ftpp_pkg::PH_CNAME;
        end
        ftpp_pkg::PH_CNAME: begin
          rem_d        = rem_q - 16'd1;
          res_valid_o  = 1'b1;
          res_o.kind   = ftpp_pkg::KIND_NAME;
          res_o.value  = {24'd0, byte_i};
          res_o.last   = (rem_q == 16'd1);
          res_o.is_end = ctl_end_q;
          if (rem_q == 16'd1) begin
            phase_d = ftpp_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_d = ftpp_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // errors and final payload/name words always drop back to idle
  `FTPP_ASSERT_NEXT(a_err_to_idle, clk_i, rst_ni,
    adv_i && res_valid_o && (res_o.kind == ftpp_pkg::KIND_FORMAT ||
    res_o.kind == ftpp_pkg::KIND_SEQ), phase_q == ftpp_pkg::PH_IDLE,
    "error result did not return parser to idle")
  `FTPP_ASSERT_NEXT(a_last_to_idle, clk_i, rst_ni,
    adv_i && res_valid_o && res_o.last, phase_q == ftpp_pkg::PH_IDLE,
    "last word did not return parser to idle")
  `FTPP_ASSERT_NOW(a_pay_phase, clk_i, rst_ni,
    res_valid_o && res_o.kind == ftpp_pkg::KIND_PAYLOAD,
    !first_i && phase_q == ftpp_pkg::PH_DPAY,
    "payload result outside payload phase")
  `FTPP_ASSERT_NOW(a_seq_range, clk_i, rst_ni, 1'b1, seq_q != 8'hFF,
    "expected sequence left modulo 255 range")

endmodule

// ----- hdl/ftpp_out_reg.sv -----
// Result register with valid/ready handshake
module ftpp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              res_valid_i,
  input  ftpp_pkg::result_t res_i,
  output logic              can_take_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ftpp_pkg::result_t res_o
);

  logic              valid_q;
  ftpp_pkg::result_t res_q;

  assign can_take_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_valid_i;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ----- hdl/file_transfer_packet_parser.sv -----
// Top level of the file transfer packet parser
//
// Input channel: one packet byte per word (pkt_byte_i, first_of_packet_i)
// under in_valid_i/in_ready_o. first_of_packet_i marks a packet's type byte
// and always restarts parsing. Output channel: zero or one result word per
// input word (kind, value, last, end flag) under out_valid_o/out_ready_i.
// Config: APB registers for the type, size tag and name tag codes; write
// only while no words are in flight.
// Throughput: one word per cycle while out_ready_i is high. A word is held
// in the input register and its result in the result register, with the
// parser logic between them.
// Stall: while out_ready_i is low with a result pending, the input register
// holds one more word and in_ready_o drops; no word is lost.
// Reset: registers return to their default codes, the parser goes idle,
// the expected sequence number returns to zero, both stages empty.
module file_transfer_packet_parser #(
  parameter int SIZE_BYTES_KEPT = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   pkt_byte_i,
  input  logic                         first_of_packet_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   out_kind_o,
  output logic [31:0]                  out_value_o,
  output logic                         out_last_o,
  output logic                         is_end_packet_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ftpp_pkg::PADDR_W-1:0] paddr,
  input  logic [ftpp_pkg::PDATA_W-1:0] pwdata,
  output logic [ftpp_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  ftpp_pkg::cfg_t    cfg;
  ftpp_pkg::result_t res, out_res;
  logic              st_valid, st_first, can_take, adv, res_valid;
  logic [7:0]        st_byte;

  assign adv = st_valid && can_take;

  ftpp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ftpp_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .byte_i     (pkt_byte_i),
    .first_i    (first_of_packet_i),
    .adv_i      (adv),
    .valid_o    (st_valid),
    .byte_o     (st_byte),
    .first_o    (st_first)
  );

  ftpp_parser #(
    .SIZE_BYTES_KEPT (SIZE_BYTES_KEPT)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .adv_i       (adv),
    .byte_i      (st_byte),
    .first_i     (st_first),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ftpp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv),
    .res_valid_i (res_valid),
    .res_i       (res),
    .can_take_o  (can_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign out_kind_o      = out_res.kind;
  assign out_value_o     = out_res.value;
  assign out_last_o      = out_res.last;
  assign is_end_packet_o = out_res.is_end;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the packet parser: directed and random packets, checked by a predictor
module tb;

  localparam int SIZE_KEEP     = 4;
  localparam int PHASE_WORDS   = 100;
  localparam int SWEEP_PACKETS = 260;
  localparam int NUM_SETTINGS  = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef enum int {PK_GOOD, PK_BAD_SEQ, PK_BAD_SIZE_TAG, PK_BAD_NAME_TAG, PK_CUT} flaw_e;

  class parser_scoreboard;
    ftpp_pkg::cfg_t    cfg;
    ftpp_pkg::phase_e  phase;
    logic [7:0]        exp_seq;
    logic [15:0]       remaining;
    logic [31:0]       size_acc;
    logic [7:0]        size_idx;
    logic              ctrl_end;
    ftpp_pkg::result_t pending_q[$];
    int                errors;
    int                checked;

    function new();
      cfg = '{ftpp_pkg::RST_DATA_TYPE, ftpp_pkg::RST_START_TYPE, ftpp_pkg::RST_END_TYPE,
              ftpp_pkg::RST_SIZE_TAG, ftpp_pkg::RST_NAME_TAG};
      phase = ftpp_pkg::PH_IDLE;
      exp_seq = '0;
      remaining = '0;
      size_acc = '0;
      size_idx = '0;
      ctrl_end = 1'b0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_cfg(logic [2:0] idx, logic [7:0] val);
      case (idx)
        ftpp_pkg::REG_DATA_TYPE:  cfg.data_type = val;
        ftpp_pkg::REG_START_TYPE: cfg.start_type = val;
        ftpp_pkg::REG_END_TYPE:   cfg.end_type = val;
        ftpp_pkg::REG_SIZE_TAG:   cfg.size_tag = val;
        ftpp_pkg::REG_NAME_TAG:   cfg.name_tag = val;
        default: ;
      endcase
    endfunction

    function void note_word(logic [7:0] b, logic f);
      ftpp_pkg::result_t r;
      logic              hit;
      logic              size_ready;
      r = '0;
      hit = 1'b0;
      size_ready = 1'b0;
      if (f) begin
        if (b == cfg.data_type) begin
          phase = ftpp_pkg::PH_DSEQ;
        end else if (b == cfg.start_type || b == cfg.end_type) begin
          ctrl_end = (b != cfg.start_type);
          phase = ftpp_pkg::PH_CTAG;
        end else begin
          phase = ftpp_pkg::PH_IDLE;
          r.kind = ftpp_pkg::KIND_FORMAT;
          hit = 1'b1;
        end
      end else begin
        case (phase)
          ftpp_pkg::PH_DSEQ: begin
            if (b != exp_seq) begin
              phase = ftpp_pkg::PH_IDLE;
              r.kind = ftpp_pkg::KIND_SEQ;
              hit = 1'b1;
            end else begin
              exp_seq = (exp_seq == ftpp_pkg::SEQ_WRAP) ? 8'd0 : exp_seq + 8'd1;
              phase = ftpp_pkg::PH_DLENH;
            end
          end
          ftpp_pkg::PH_DLENH: begin
            remaining = {b, 8'h00};
            phase = ftpp_pkg::PH_DLENL;
          end
          ftpp_pkg::PH_DLENL: begin
            remaining = remaining | {8'h00, b};
            phase = (remaining == 16'd0) ? ftpp_pkg::PH_IDLE : ftpp_pkg::PH_DPAY;
          end
          ftpp_pkg::PH_DPAY: begin
            r.kind = ftpp_pkg::KIND_PAYLOAD;
            r.value = {24'h0, b};
            r.last = (remaining == 16'd1);
            remaining = remaining - 16'd1;
            if (remaining == 16'd0) phase = ftpp_pkg::PH_IDLE;
            hit = 1'b1;
          end
          ftpp_pkg::PH_CTAG: begin
            if (b != cfg.size_tag) begin
              phase = ftpp_pkg::PH_IDLE;
              r.kind = ftpp_pkg::KIND_FORMAT;
              hit = 1'b1;
            end else begin
              phase = ftpp_pkg::PH_CSLEN;
            end
          end
          ftpp_pkg::PH_CSLEN: begin
            size_acc = '0;
            size_idx = '0;
            remaining = {8'h00, b};
            if (b == 8'd0) size_ready = 1'b1;
            else phase = ftpp_pkg::PH_CSIZE;
          end
          ftpp_pkg::PH_CSIZE: begin
            if (size_idx < SIZE_KEEP && size_idx < 4)
              size_acc = size_acc | ({24'h0, b} << (8 * size_idx));
            size_idx = size_idx + 8'd1;
            remaining = remaining - 16'd1;
            if (remaining == 16'd0) size_ready = 1'b1;
          end
          ftpp_pkg::PH_CNTAG: begin
            if (b != cfg.name_tag) begin
              phase = ftpp_pkg::PH_IDLE;
              r.kind = ftpp_pkg::KIND_FORMAT;
              hit = 1'b1;
            end else begin
              phase = ftpp_pkg::PH_CNLEN;
            end
          end
          ftpp_pkg::PH_CNLEN: begin
            remaining = {8'h00, b};
            phase = (b == 8'd0) ? ftpp_pkg::PH_IDLE : ftpp_pkg::PH_CNAME;
          end
          ftpp_pkg::PH_CNAME: begin
            r.kind = ftpp_pkg::KIND_NAME;
            r.value = {24'h0, b};
            r.last = (remaining == 16'd1);
            r.is_end = ctrl_end;
            remaining = remaining - 16'd1;
            if (remaining == 16'd0) phase = ftpp_pkg::PH_IDLE;
            hit = 1'b1;
          end
          default: phase = ftpp_pkg::PH_IDLE;
        endcase
      end
      if (size_ready) begin
        phase = ftpp_pkg::PH_CNTAG;
        r.kind = ftpp_pkg::KIND_SIZE;
        r.value = size_acc;
        r.is_end = ctrl_end;
        hit = 1'b1;
      end
      if (hit) pending_q.push_back(r);
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(ftpp_pkg::result_t got);
      ftpp_pkg::result_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d value %h", got.kind, got.value));
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.value !== want.value)
        report($sformatf("value %h, expected %h", got.value, want.value));
      if (got.last !== want.last)
        report($sformatf("last %b, expected %b", got.last, want.last));
      if (got.is_end !== want.is_end)
        report($sformatf("end flag %b, expected %b", got.is_end, want.is_end));
    endtask
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [7:0]                    pkt_byte_i = '0;
  logic                          first_of_packet_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [2:0]                    out_kind_o;
  logic [31:0]                   out_value_o;
  logic                          out_last_o;
  logic                          is_end_packet_o;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [ftpp_pkg::PADDR_W-1:0]  paddr = '0;
  logic [ftpp_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [ftpp_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  parser_scoreboard sb;
  logic [8:0] word_q[$];
  logic       calm = 1'b0;
  int         words_in = 0;
  int         ready_hold = 0;

  // bit 8 marks the first byte of a packet
  logic [8:0] directed_words [25] = '{
    9'h0FF,
    9'h101, 9'h000, 9'h000, 9'h002, 9'h000, 9'h0FF,
    9'h101, 9'h007,
    9'h1FF,
    9'h102, 9'h000, 9'h000, 9'h001, 9'h001, 9'h080,
    9'h103, 9'h000, 9'h005, 9'h011, 9'h022, 9'h033, 9'h044, 9'h055, 9'h002
  };

  ftpp_pkg::cfg_t settings [NUM_SETTINGS] = '{
    '{ftpp_pkg::RST_DATA_TYPE, ftpp_pkg::RST_START_TYPE, ftpp_pkg::RST_END_TYPE,
      ftpp_pkg::RST_SIZE_TAG, ftpp_pkg::RST_NAME_TAG},
    '{8'h00, 8'hFF, 8'h80, 8'hFF, 8'h00},
    '{8'h10, 8'h10, 8'h20, 8'h80, 8'h80},
    '{8'h40, 8'h41, 8'h41, 8'h7F, 8'h01},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 8'h01, 8'h00, 8'h00, 8'hFF}
  };

  file_transfer_packet_parser #(.SIZE_BYTES_KEPT(SIZE_KEEP)) u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .pkt_byte_i,
    .first_of_packet_i,
    .out_valid_o,
    .out_ready_i,
    .out_kind_o,
    .out_value_o,
    .out_last_o,
    .is_end_packet_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
      out_ready_i <= 1'b0;
    end else begin
      ready_hold = pick_gap();
      out_ready_i <= (ready_hold == 0);
    end
  end

  always @(posedge clk_i) begin
    ftpp_pkg::result_t got;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      got.kind = ftpp_pkg::kind_e'(out_kind_o);
      got.value = out_value_o;
      got.last = out_last_o;
      got.is_end = is_end_packet_o;
      sb.check_word(got);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  function automatic void push(logic [7:0] b, logic f);
    word_q.push_back({f, b});
  endfunction

  function automatic void build_data(flaw_e flaw, logic tiny);
    logic [15:0] len;
    int          n;
    push(sb.cfg.data_type, 1'b1);
    if (flaw == PK_BAD_SEQ) begin
      push(sb.exp_seq ^ 8'($urandom_range(1, 255)), 1'b0);
      return;
    end
    push(sb.exp_seq, 1'b0);
    if (tiny) len = 16'($urandom_range(0, 2));
    else if (flaw == PK_CUT) len = 16'($urandom);
    else if ($urandom_range(0, 24) == 0) len = 16'($urandom_range(256, 400));
    else len = 16'($urandom_range(0, 6));
    push(len[15:8], 1'b0);
    push(len[7:0], 1'b0);
    n = (flaw == PK_CUT) ? $urandom_range(0, 4) : int'(len);
    repeat (n) push(8'($urandom), 1'b0);
  endfunction

  function automatic void build_ctrl(flaw_e flaw);
    logic       is_end;
    logic [7:0] slen;
    logic [7:0] nlen;
    int         keep;
    is_end = 1'($urandom_range(0, 1));
    push(is_end ? sb.cfg.end_type : sb.cfg.start_type, 1'b1);
    if (flaw == PK_BAD_SIZE_TAG) begin
      push(sb.cfg.size_tag ^ 8'($urandom_range(1, 255)), 1'b0);
      return;
    end
    push(sb.cfg.size_tag, 1'b0);
    slen = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
    push(slen, 1'b0);
    repeat (slen) push(8'($urandom), 1'b0);
    if (flaw == PK_BAD_NAME_TAG) begin
      push(sb.cfg.name_tag ^ 8'($urandom_range(1, 255)), 1'b0);
      return;
    end
    push(sb.cfg.name_tag, 1'b0);
    nlen = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
    push(nlen, 1'b0);
    repeat (nlen) push(8'($urandom), 1'b0);
    if (flaw == PK_CUT) begin
      keep = $urandom_range(1, word_q.size() - 1);
      while (word_q.size() > keep) void'(word_q.pop_back());
    end
  endfunction

  task automatic send_word(logic [7:0] b, logic f);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pkt_byte_i <= b;
    first_of_packet_i <= f;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_word(b, f);
    words_in++;
  endtask

  task automatic send_all();
    logic [8:0] w;
    while (word_q.size() > 0) begin
      w = word_q.pop_front();
      send_word(w[7:0], w[8]);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_xfer(logic [2:0] idx, logic wr, logic [7:0] wdata,
                          output logic [ftpp_pkg::PDATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, wdata};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    if (wr) sb.write_cfg(idx, wdata);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [7:0] val);
    logic [ftpp_pkg::PDATA_W-1:0] unused;
    apb_xfer(idx, 1'b1, val, unused);
  endtask

  task automatic check_regs();
    logic [ftpp_pkg::PDATA_W-1:0] got;
    logic [7:0]                   want;
    for (int i = ftpp_pkg::REG_DATA_TYPE; i <= ftpp_pkg::REG_NAME_TAG; i++) begin
      apb_xfer(3'(i), 1'b0, 8'h00, got);
      case (3'(i))
        ftpp_pkg::REG_DATA_TYPE:  want = sb.cfg.data_type;
        ftpp_pkg::REG_START_TYPE: want = sb.cfg.start_type;
        ftpp_pkg::REG_END_TYPE:   want = sb.cfg.end_type;
        ftpp_pkg::REG_SIZE_TAG:   want = sb.cfg.size_tag;
        default:                  want = sb.cfg.name_tag;
      endcase
      if (got !== {24'h0, want})
        sb.report($sformatf("register %0d reads %h, expected %h", i, got, want));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    int pick;
    int phase_words;
    sb = new();
    settings[4].data_type = 8'($urandom);
    settings[4].start_type = 8'($urandom);
    settings[4].end_type = 8'($urandom);
    settings[4].size_tag = 8'($urandom);
    settings[4].name_tag = 8'($urandom);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_regs();

    foreach (directed_words[i]) push(directed_words[i][7:0], directed_words[i][8]);
    send_all();

    // enough short data packets to wrap the sequence number
    for (int k = 0; k < SWEEP_PACKETS; k++) begin
      if ($urandom_range(0, 29) == 0) calm = !calm;
      build_data(PK_GOOD, 1'b1);
      send_all();
    end

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      if (p > 0) begin
        settle();
        cfg_write(ftpp_pkg::REG_DATA_TYPE, settings[p].data_type);
        cfg_write(ftpp_pkg::REG_START_TYPE, settings[p].start_type);
        cfg_write(ftpp_pkg::REG_END_TYPE, settings[p].end_type);
        cfg_write(ftpp_pkg::REG_SIZE_TAG, settings[p].size_tag);
        cfg_write(ftpp_pkg::REG_NAME_TAG, settings[p].name_tag);
        cfg_write(REG_UNUSED, 8'($urandom));
        check_regs();
      end
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        if ($urandom_range(0, 29) == 0) calm = !calm;
        pick = $urandom_range(0, 99);
        if (pick < 40) build_data(PK_GOOD, 1'b0);
        else if (pick < 70) build_ctrl(PK_GOOD);
        else if (pick < 76) build_data(PK_BAD_SEQ, 1'b0);
        else if (pick < 80) build_data(PK_CUT, 1'b0);
        else if (pick < 84) build_ctrl(PK_BAD_SIZE_TAG);
        else if (pick < 88) build_ctrl(PK_BAD_NAME_TAG);
        else if (pick < 92) build_ctrl(PK_CUT);
        else repeat ($urandom_range(1, 6)) push(8'($urandom), $urandom_range(0, 3) == 0);
        if (pick < 92) phase_words += word_q.size();
        send_all();
      end
    end

    settle();
    $display("Run: %0d words in, %0d results compared, %0d register settings",
             words_in, sb.checked, NUM_SETTINGS);
    $display("Covered data and control packets, sequence wrap, bad types and tags,");
    $display("bad sequence numbers, cut packets and stray bytes");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/ftpp_pkg.sv
hdl/ftpp_cfg_regs.sv
hdl/ftpp_in_reg.sv
hdl/ftpp_parser.sv
hdl/ftpp_out_reg.sv
hdl/file_transfer_packet_parser.sv
bench/tb.sv
